@@ design/y2rgb_pkg.sv @@
// Shared types, constants and helpers for the YUYV to RGB888 converter.
package y2rgb_pkg;

  localparam int unsigned GAIN_W  = 10;
  localparam int unsigned COEF_W  = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ACC_W   = 22;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIX_W   = 24;

  localparam logic [IDX_W-1:0] REG_LUMA_GAIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_RED_FROM_V   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GREEN_FROM_U = 3'd2;
  localparam logic [IDX_W-1:0] REG_GREEN_FROM_V = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLUE_FROM_U  = 3'd4;

  localparam logic [GAIN_W-1:0]        RST_LUMA_GAIN    = 10'd298;
  localparam logic signed [COEF_W-1:0] RST_RED_FROM_V   = 11'sd297;
  localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_U = 11'sd97;
  localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_V = 11'sd208;
  localparam logic signed [COEF_W-1:0] RST_BLUE_FROM_U  = 11'sd517;

  typedef struct packed {
    logic [GAIN_W-1:0]        luma_gain;
    logic signed [COEF_W-1:0] red_from_v;
    logic signed [COEF_W-1:0] green_from_u;
    logic signed [COEF_W-1:0] green_from_v;
    logic signed [COEF_W-1:0] blue_from_u;
  } coef_t;

  // Round half up by +128, floor by arithmetic shift, then saturate to 0..255.
  function automatic logic [CHAN_W-1:0] finish_channel(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-9:0] q;
    t = acc + ACC_W'(128);
    q = t[ACC_W-1:8];
    if (q < 0) begin
      finish_channel = '0;
    end else if (q > $signed((ACC_W-8)'(255))) begin
      finish_channel = '1;
    end else begin
      finish_channel = q[CHAN_W-1:0];
    end
  endfunction

endpackage

@@ design/y2rgb_cfg_regs.sv @@
// Coefficient register bank written through the plain configuration port.
module y2rgb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [y2rgb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [y2rgb_pkg::CFG_W-1:0]     cfg_wdata,
  output y2rgb_pkg::coef_t                coef
);

  y2rgb_pkg::coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.luma_gain    <= y2rgb_pkg::RST_LUMA_GAIN;
      coef_r.red_from_v   <= y2rgb_pkg::RST_RED_FROM_V;
      coef_r.green_from_u <= y2rgb_pkg::RST_GREEN_FROM_U;
      coef_r.green_from_v <= y2rgb_pkg::RST_GREEN_FROM_V;
      coef_r.blue_from_u  <= y2rgb_pkg::RST_BLUE_FROM_U;
    end else if (cfg_we) begin
      case (cfg_index)
        y2rgb_pkg::REG_LUMA_GAIN:    coef_r.luma_gain    <= cfg_wdata[y2rgb_pkg::GAIN_W-1:0];
        y2rgb_pkg::REG_RED_FROM_V:   coef_r.red_from_v   <= $signed(cfg_wdata);
        y2rgb_pkg::REG_GREEN_FROM_U: coef_r.green_from_u <= $signed(cfg_wdata);
        y2rgb_pkg::REG_GREEN_FROM_V: coef_r.green_from_v <= $signed(cfg_wdata);
        y2rgb_pkg::REG_BLUE_FROM_U:  coef_r.blue_from_u  <= $signed(cfg_wdata);
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign coef = coef_r;

endmodule

@@ design/y2rgb_pixel.sv @@
// Color matrix for one pixel: three Q8 sums, rounding and saturation.
module y2rgb_pixel (
  input  logic [7:0]                      luma,
  input  logic signed [8:0]               cb,
  input  logic signed [8:0]               cr,
  input  y2rgb_pkg::coef_t                coef,
  output logic [y2rgb_pkg::PIX_W-1:0]     pixel
);

  localparam int unsigned AW = y2rgb_pkg::ACC_W;

  logic signed [9:0]    luma_d;
  logic signed [10:0]   gain_s;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] rv_term;
  logic signed [AW-1:0] gu_term;
  logic signed [AW-1:0] gv_term;
  logic signed [AW-1:0] bu_term;
  logic signed [AW-1:0] red_acc;
  logic signed [AW-1:0] green_acc;
  logic signed [AW-1:0] blue_acc;

  always_comb begin
    luma_d  = $signed({2'b00, luma}) - 10'sd16;
    gain_s  = $signed({1'b0, coef.luma_gain});
    base    = AW'(gain_s * luma_d);
    rv_term = AW'(coef.red_from_v * cr);
    gu_term = AW'(coef.green_from_u * cb);
    gv_term = AW'(coef.green_from_v * cr);
    bu_term = AW'(coef.blue_from_u * cb);

    red_acc   = base + rv_term;
    green_acc = base - gu_term + gv_term;
    blue_acc  = base + bu_term;

    pixel = {y2rgb_pkg::finish_channel(red_acc),
             y2rgb_pkg::finish_channel(green_acc),
             y2rgb_pkg::finish_channel(blue_acc)};
  end

endmodule

@@ design/yuyv_to_rgb888_converter.sv @@
// Top level of the YUYV 4:2:2 macropixel to dual RGB888 pixel converter.
// One macropixel transfer in, one transfer of two packed RGB888 pixels out.
// The block takes one macropixel every cycle while the output side keeps
// accepting; the color matrix for both pixels sits in one combinational pass
// between the input and result registers. Luma gain is unsigned Q8, the other
// coefficients signed Q8; reset loads the default set. The user writes them
// via the cfg port only while the stream is idle; not enforced by the block.
module yuyv_to_rgb888_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: y_first[7:0], u_chroma[15:8], y_second[23:16], v_chroma[31:24]
  input  logic [31:0]                       in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: pixel_first[23:0], pixel_second[47:24]
  output logic [47:0]                       out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [y2rgb_pkg::IDX_W-1:0]       cfg_index,
  input  logic [y2rgb_pkg::CFG_W-1:0]       cfg_wdata
);

  y2rgb_pkg::coef_t coef;

  logic        in_valid_r;
  logic [31:0] in_data_r;
  logic        in_last_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_last_r;
  logic        out_load;

  logic signed [8:0]              cb;
  logic signed [8:0]              cr;
  logic [y2rgb_pkg::PIX_W-1:0]    pixel_first;
  logic [y2rgb_pkg::PIX_W-1:0]    pixel_second;

  y2rgb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // Result register frees when empty or being taken; input register follows.
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  assign cb = $signed({1'b0, in_data_r[15:8]}) - 9'sd128;
  assign cr = $signed({1'b0, in_data_r[31:24]}) - 9'sd128;

  y2rgb_pixel u_pix_first (
    .luma  (in_data_r[7:0]),
    .cb    (cb),
    .cr    (cr),
    .coef  (coef),
    .pixel (pixel_first)
  );

  y2rgb_pixel u_pix_second (
    .luma  (in_data_r[23:16]),
    .cb    (cb),
    .cr    (cr),
    .coef  (coef),
    .pixel (pixel_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid_r) begin
      out_data_r <= {pixel_second, pixel_first};
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the YUYV to RGB888 converter: directed corners, then random streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUMA_BLACK     = 16;
  localparam int CHROMA_ZERO    = 128;
  localparam int ROUND_HALF     = 128;
  localparam int CHANNEL_MAX    = 255;
  localparam int GAIN_MAX       = 1023;
  localparam int COEF_MIN       = -1024;
  localparam int COEF_MAX       = 1023;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [y2rgb_pkg::PIX_W-1:0] pixel_first;
    logic [y2rgb_pkg::PIX_W-1:0] pixel_second;
    logic                        frame_done;
  } rgb_pair_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic [31:0]                  in_tdata = '0;
  logic                         in_tlast = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [47:0]                  out_tdata;
  logic                         out_tlast;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [y2rgb_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [y2rgb_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // Predictor copy of the coefficient registers, signed ones sign-extended
  int gain_q8    = y2rgb_pkg::RST_LUMA_GAIN;
  int red_v_q8   = y2rgb_pkg::RST_RED_FROM_V;
  int green_u_q8 = y2rgb_pkg::RST_GREEN_FROM_U;
  int green_v_q8 = y2rgb_pkg::RST_GREEN_FROM_V;
  int blue_u_q8  = y2rgb_pkg::RST_BLUE_FROM_U;

  rgb_pair_t expected_pairs[$];
  int  fail_count = 0;
  int  pairs_in = 0;
  int  pairs_out = 0;
  int  reg_writes = 0;
  int  settings_used = 1;
  int  gap_pct = 20;
  int  stall_pct = 20;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  yuyv_to_rgb888_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] clamp_q8(input int acc);
    int q;
    q = (acc + ROUND_HALF) >>> 8;
    if (q < 0) return 8'd0;
    if (q > CHANNEL_MAX) return 8'(CHANNEL_MAX);
    return q[7:0];
  endfunction

  function automatic logic [y2rgb_pkg::PIX_W-1:0] rgb_pixel(input logic [7:0] y, input int cb,
                                                            input int cr);
    int base;
    base = gain_q8 * (int'(y) - LUMA_BLACK);
    return {clamp_q8(base + red_v_q8 * cr),
            clamp_q8(base - green_u_q8 * cb + green_v_q8 * cr),
            clamp_q8(base + blue_u_q8 * cb)};
  endfunction

  function automatic rgb_pair_t convert_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                                   input logic [7:0] y1, input logic [7:0] v,
                                                   input logic last);
    rgb_pair_t p;
    int cb;
    int cr;
    cb = int'(u) - CHROMA_ZERO;
    cr = int'(v) - CHROMA_ZERO;
    p.pixel_first  = rgb_pixel(y0, cb, cr);
    p.pixel_second = rgb_pixel(y1, cb, cr);
    p.frame_done   = last;
    return p;
  endfunction

  // Result side: random stall bursts, none in the quiet tail
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rgb_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pairs_out++;
      if (expected_pairs.size() == 0) begin
        $error("result transfer with nothing expected: tdata %012h tlast %0b",
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_tdata[y2rgb_pkg::PIX_W-1:0] !== want.pixel_first) begin
          $error("pixel_first: expected %06h, actual %06h", want.pixel_first,
                 out_tdata[y2rgb_pkg::PIX_W-1:0]);
          fail_count++;
        end
        if (out_tdata[2*y2rgb_pkg::PIX_W-1:y2rgb_pkg::PIX_W] !== want.pixel_second) begin
          $error("pixel_second: expected %06h, actual %06h", want.pixel_second,
                 out_tdata[2*y2rgb_pkg::PIX_W-1:y2rgb_pkg::PIX_W]);
          fail_count++;
        end
        if (out_tlast !== want.frame_done) begin
          $error("frame_done: expected %0b, actual %0b", want.frame_done, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("yuyv_to_rgb888_converter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called right after a rising edge; returns at the edge that takes the transfer
  task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                 input logic [7:0] y1, input logic [7:0] v,
                                 input logic last);
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, y1, u, y0};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    expected_pairs.push_back(convert_macropixel(y0, u, y1, v, last));
    pairs_in++;
  endtask

  task automatic send_random_macropixel();
    logic [7:0] y0, u, y1, v;
    logic       last;
    case ($urandom_range(0, 9))
      0, 1: begin
        // studio-range content
        y0 = 8'($urandom_range(16, 235));
        y1 = 8'($urandom_range(16, 235));
        u  = 8'($urandom_range(16, 240));
        v  = 8'($urandom_range(16, 240));
      end
      2: begin
        y0 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        y1 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        u  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        v  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      default: {y0, u, y1, v} = $urandom;
    endcase
    last = ($urandom_range(0, 7) == 0);
    send_macropixel(y0, u, y1, v, last);
  endtask

  // Drop valid, wait for every expected pair, then let the pipeline empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_register(input logic [y2rgb_pkg::IDX_W-1:0] idx,
                                input logic [y2rgb_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    reg_writes++;
    case (idx)
      y2rgb_pkg::REG_LUMA_GAIN:
        gain_q8    = int'(data[y2rgb_pkg::GAIN_W-1:0]);
      y2rgb_pkg::REG_RED_FROM_V:
        red_v_q8   = int'($signed(data[y2rgb_pkg::COEF_W-1:0]));
      y2rgb_pkg::REG_GREEN_FROM_U:
        green_u_q8 = int'($signed(data[y2rgb_pkg::COEF_W-1:0]));
      y2rgb_pkg::REG_GREEN_FROM_V:
        green_v_q8 = int'($signed(data[y2rgb_pkg::COEF_W-1:0]));
      y2rgb_pkg::REG_BLUE_FROM_U:
        blue_u_q8  = int'($signed(data[y2rgb_pkg::COEF_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic program_coefs(input int gain, input int red_v, input int green_u,
                               input int green_v, input int blue_u);
    write_register(y2rgb_pkg::REG_LUMA_GAIN, y2rgb_pkg::CFG_W'(gain));
    write_register(y2rgb_pkg::REG_RED_FROM_V, y2rgb_pkg::CFG_W'(red_v));
    write_register(y2rgb_pkg::REG_GREEN_FROM_U, y2rgb_pkg::CFG_W'(green_u));
    write_register(y2rgb_pkg::REG_GREEN_FROM_V, y2rgb_pkg::CFG_W'(green_v));
    write_register(y2rgb_pkg::REG_BLUE_FROM_U, y2rgb_pkg::CFG_W'(blue_u));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      1:       return int'($urandom_range(0, 2047)) + COEF_MIN;
      default: return int'($urandom_range(0, 700)) - 200;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_macropixel(8'd16, 8'd128, 8'd16, 8'd128, 1'b0);
    send_macropixel(8'd235, 8'd128, 8'd235, 8'd128, 1'b0);
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_macropixel(8'd128, 8'd128, 8'd200, 8'd128, 1'b1);
    send_macropixel(8'd81, 8'd90, 8'd81, 8'd240, 1'b0);
    send_macropixel(8'd41, 8'd240, 8'd41, 8'd110, 1'b0);
    send_macropixel(8'd145, 8'd54, 8'd145, 8'd34, 1'b1);
  endtask

  task automatic test_extreme_coefs();
    wait_idle();
    program_coefs(GAIN_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_macropixel(8'd16, 8'd0, 8'd16, 8'd255, 1'b0);
    wait_idle();
    program_coefs(0, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_macropixel(8'd16, 8'd255, 8'd16, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    wait_idle();
    // top bit of the gain write is beyond the register and must be dropped
    program_coefs((GAIN_MAX + 1) + 1, 1, -1, 1, -1);
    @(posedge clk);
    // writes past the last register must change nothing
    for (int idx = y2rgb_pkg::REG_BLUE_FROM_U + 1; idx < (1 << y2rgb_pkg::IDX_W); idx++) begin
      write_register(y2rgb_pkg::IDX_W'(idx), '1);
    end
    cfg_we <= 1'b0;
    // tiny negative sums: rounding has to floor toward minus infinity
    send_macropixel(8'd15, 8'd129, 8'd17, 8'd127, 1'b0);
    send_macropixel(8'd200, 8'd131, 8'd240, 8'd125, 1'b1);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      gap_pct   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 15 : 50);
      stall_pct = (phase < 3) ? 10 * phase : 50 - 10 * phase;
      if (phase == 0) begin
        program_coefs(y2rgb_pkg::RST_LUMA_GAIN, y2rgb_pkg::RST_RED_FROM_V,
                      y2rgb_pkg::RST_GREEN_FROM_U, y2rgb_pkg::RST_GREEN_FROM_V,
                      y2rgb_pkg::RST_BLUE_FROM_U);
      end else begin
        program_coefs($urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(200, 400),
                      pick_coef(), pick_coef(), pick_coef(), pick_coef());
      end
      repeat (100) send_random_macropixel();
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    quiet = 1'b1;
    program_coefs(y2rgb_pkg::RST_LUMA_GAIN, y2rgb_pkg::RST_RED_FROM_V,
                  y2rgb_pkg::RST_GREEN_FROM_U, y2rgb_pkg::RST_GREEN_FROM_V,
                  y2rgb_pkg::RST_BLUE_FROM_U);
    repeat (150) send_random_macropixel();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_coefs();
    test_random_settings();
    test_steady_stream();
    wait_idle();
    $display("converted %0d macropixels into %0d pixel pairs under %0d coefficient sets",
             pairs_in, pairs_out, settings_used);
    $display("%0d register writes, reserved indexes and gain overflow bit included",
             reg_writes);
    if (fail_count == 0) begin
      $display("yuyv_to_rgb888_converter regression: pass");
    end else begin
      $display("yuyv_to_rgb888_converter regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/y2rgb_pkg.sv
design/y2rgb_cfg_regs.sv
design/y2rgb_pixel.sv
design/yuyv_to_rgb888_converter.sv
tb/tb.sv
